// File: src/swos_pkg.sv
`timescale 1ns / 1ps

package swos_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // fixed field widths
    localparam int FRAC_W      = 17;
    localparam int Q_FRAC_BITS = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam int LEN_RESET   = 20;
    localparam logic [FRAC_W-1:0] QUANT_RESET = 17'd32768;
    localparam logic [FRAC_W-1:0] QUANT_ONE   = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_HALF   = 17'd32768;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic {
        REG_WINDOW_LENGTH = 1'b0,
        REG_QUANTILE      = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic wr_len;
        logic wr_quant;
    } cfg_wr_t;

    typedef struct packed {
        logic remove;
        logic insert;
    } cells_cmd_t;

endpackage

// File: src/sliding_window_order_statistics.sv
`timescale 1ns / 1ps
// each sample passes through eviction (once the window is full), insert, position, cell reads,
// quantile multiply, rank-fraction division and output; the engine takes the next sample only
// once output completes, which waits on a full output register; the divider is the longest step
// a two-entry input queue keeps taking samples while the engine and output register are busy
// reset (aresetn low, synchronous) empties the window, length 20, quantile 0.5

module sliding_window_order_statistics import swos_pkg::*; #(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CNT_W = $clog2(WINDOW_MAX + 1),
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_RAW_W = 4 * SAMPLE_BITS + 2 * CNT_W + FRAC_W,
    localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // window_max, window_min, median_value, quantile_value, sample_rank,
    // rank_fraction, window_count
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(WINDOW_MAX);

    cfg_wr_t                cfg;
    reg_index_t             reg_sel;
    logic                   apb_wr;
    logic [CNT_W-1:0]       len_val;
    logic [FRAC_W-1:0]      quant_val;

    logic                   q_valid;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] q_data;

    cells_cmd_t             cells_cmd;
    logic [SAMPLE_BITS-1:0] op_value;
    logic [CNT_W-1:0]       fill;
    logic [IDX_W-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] min_data;
    logic [CNT_W-1:0]       below;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic [SAMPLE_BITS-1:0] r_max;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_med;
    logic [SAMPLE_BITS-1:0] r_quant;
    logic [CNT_W-1:0]       r_rank;
    logic [FRAC_W-1:0]      r_frac;
    logic [CNT_W-1:0]       r_count;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[2]);
    assign cfg.wr_len   = apb_wr && (reg_sel == REG_WINDOW_LENGTH);
    assign cfg.wr_quant = apb_wr && (reg_sel == REG_QUANTILE);
    assign prdata  = (reg_sel == REG_QUANTILE) ? CFG_DATA_W'(quant_val) : CFG_DATA_W'(len_val);

    swos_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_tdata[SAMPLE_BITS-1:0]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    swos_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_arrival_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swos_cells #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cells (
        .aclk     (aclk),
        .cmd      (cells_cmd),
        .op_value (op_value),
        .fill     (fill),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .min_data (min_data),
        .below    (below)
    );

    swos_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cfg_data         (pwdata),
        .len_out          (len_val),
        .quant_out        (quant_val),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_data           (q_data),
        .cells_cmd        (cells_cmd),
        .op_value         (op_value),
        .fill             (fill),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .min_data         (min_data),
        .below            (below),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_window_max     (r_max),
        .m_window_min     (r_min),
        .m_median_value   (r_med),
        .m_quantile_value (r_quant),
        .m_sample_rank    (r_rank),
        .m_rank_fraction  (r_frac),
        .m_window_count   (r_count)
    );

    assign m_tdata = OUT_W'({r_count, r_frac, r_rank, r_quant, r_med, r_min, r_max});

endmodule

// File: src/swos_ram.sv
`timescale 1ns / 1ps

module swos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/swos_front.sv
`timescale 1ns / 1ps

module swos_front import swos_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   q_valid,
    input  logic                   q_pop,
    output logic [SAMPLE_BITS-1:0] q_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   push;
    logic                   pop;

    assign s_tready = (cnt_reg != CNT_W'(FIFO_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // offset-binary so the sorter compares unsigned
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_sample ^ SIGN_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/swos_cells.sv
`timescale 1ns / 1ps

module swos_cells import swos_pkg::*; #(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  cells_cmd_t                           cmd,
    input  logic [SAMPLE_BITS-1:0]               op_value,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]      fill,
    input  logic [$clog2(WINDOW_MAX)-1:0]        rd_addr,
    output logic [SAMPLE_BITS-1:0]               rd_data,
    output logic [SAMPLE_BITS-1:0]               min_data,
    output logic [$clog2(WINDOW_MAX+1)-1:0]      below
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [SAMPLE_BITS-1:0] cell_reg [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  match;
    logic [WINDOW_MAX-1:0]  lt;
    logic [WINDOW_MAX-1:0]  hit;
    logic [WINDOW_MAX-1:0]  lt_up;
    logic [WINDOW_MAX-1:0]  lt_edge;

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
            logic                   valid;
            logic                   prev_lt;
            logic [SAMPLE_BITS-1:0] up_val;
            logic [SAMPLE_BITS-1:0] down_val;

            assign valid    = (CNT_W'(g) < fill);
            assign match[g] = valid && (cell_reg[g] == op_value);
            assign lt[g]    = valid && (cell_reg[g] < op_value);
            // first match at or below this cell: shift down by one
            assign hit[g]   = |(match & ({WINDOW_MAX{1'b1}} >> (WINDOW_MAX - 1 - g)));

            if (g == 0) begin : g_first
                assign prev_lt  = 1'b1;
                assign down_val = cell_reg[g];
            end else begin : g_rest
                assign prev_lt  = lt[g-1];
                assign down_val = cell_reg[g-1];
            end

            if (g == WINDOW_MAX - 1) begin : g_last
                assign up_val = cell_reg[g];
            end else begin : g_inner
                assign up_val = cell_reg[g+1];
            end

            always_ff @(posedge aclk) begin
                if (cmd.remove) begin
                    if (hit[g]) begin
                        cell_reg[g] <= up_val;
                    end
                end else if (cmd.insert) begin
                    if (!lt[g]) begin
                        cell_reg[g] <= prev_lt ? op_value : down_val;
                    end
                end
            end
        end
    endgenerate

    // lt is a prefix of ones; its top edge gives the count below
    assign lt_up   = {1'b0, lt[WINDOW_MAX-1:1]};
    assign lt_edge = lt & ~lt_up;

    always_comb begin
        below = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            below = below | (lt_edge[i] ? CNT_W'(i + 1) : '0);
        end
    end

    assign rd_data  = cell_reg[rd_addr];
    assign min_data = cell_reg[0];

endmodule

// File: src/swos_back.sv
`timescale 1ns / 1ps

module swos_back import swos_pkg::*; #(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cfg_wr_t                             cfg,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    output logic [$clog2(WINDOW_MAX+1)-1:0]     len_out,
    output logic [FRAC_W-1:0]                   quant_out,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  logic [SAMPLE_BITS-1:0]              q_data,
    output cells_cmd_t                          cells_cmd,
    output logic [SAMPLE_BITS-1:0]              op_value,
    output logic [$clog2(WINDOW_MAX+1)-1:0]     fill,
    output logic [$clog2(WINDOW_MAX)-1:0]       rd_addr,
    input  logic [SAMPLE_BITS-1:0]              rd_data,
    input  logic [SAMPLE_BITS-1:0]              min_data,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]     below,
    output logic                                ram_we,
    output logic [$clog2(WINDOW_MAX)-1:0]       ram_waddr,
    output logic [SAMPLE_BITS-1:0]              ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(WINDOW_MAX)-1:0]       ram_raddr,
    input  logic [SAMPLE_BITS-1:0]              ram_rdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [SAMPLE_BITS-1:0]              m_window_max,
    output logic [SAMPLE_BITS-1:0]              m_window_min,
    output logic [SAMPLE_BITS-1:0]              m_median_value,
    output logic [SAMPLE_BITS-1:0]              m_quantile_value,
    output logic [$clog2(WINDOW_MAX+1)-1:0]     m_sample_rank,
    output logic [FRAC_W-1:0]                   m_rank_fraction,
    output logic [$clog2(WINDOW_MAX+1)-1:0]     m_window_count
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int POS_W = FRAC_W + CNT_W;
    localparam int LO_W  = POS_W - Q_FRAC_BITS;
    localparam int PROD_W = SAMPLE_BITS + Q_FRAC_BITS;
    localparam int DIV_W = CNT_W + Q_FRAC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_EVRD, S_REMOVE, S_INSERT, S_POS, S_RD, S_QMUL, S_DIV, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        RD_MAX, RD_MED_HI, RD_MED_LO, RD_Q_LO, RD_Q_HI
    } rd_step_t;

    state_t                 state_reg;
    rd_step_t               step_reg;
    logic [CNT_W-1:0]       len_reg;
    logic [FRAC_W-1:0]      quant_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [IDX_W-1:0]       oldest_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CNT_W-1:0]       below_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] med_hi_reg;
    logic [SAMPLE_BITS-1:0] med_lo_reg;
    logic [SAMPLE_BITS-1:0] qa_reg;
    logic [SAMPLE_BITS-1:0] qb_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   use_a_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [DIV_W-1:0]       quot_reg;
    logic [DCNT_W-1:0]      div_cnt_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_max_reg;
    logic [SAMPLE_BITS-1:0] out_min_reg;
    logic [SAMPLE_BITS-1:0] out_med_reg;
    logic [SAMPLE_BITS-1:0] out_quant_reg;
    logic [CNT_W-1:0]       out_rank_reg;
    logic [FRAC_W-1:0]      out_frac_reg;
    logic [CNT_W-1:0]       out_count_reg;

    logic [CNT_W-1:0]       len_clamped;
    logic [CNT_W:0]         slot_sum;
    logic [CNT_W:0]         slot_wrap;
    logic [IDX_W-1:0]       oldest_inc;
    logic [CNT_W-1:0]       n_m1;
    logic [CNT_W-1:0]       half;
    logic [IDX_W-1:0]       half_lo;
    logic [LO_W-1:0]        lo_full;
    logic [Q_FRAC_BITS-1:0] pos_f;
    logic [IDX_W-1:0]       lo_addr;
    logic [IDX_W-1:0]       lo_next_addr;
    logic [CNT_W:0]         rem_sh;
    logic [SAMPLE_BITS-1:0] med_a;
    logic [SAMPLE_BITS-1:0] med_sum;
    logic [SAMPLE_BITS-1:0] quant_sum;
    logic [SAMPLE_BITS-1:0] quant_res;

    always_comb begin
        len_clamped = cfg_data[CNT_W-1:0];
        if (len_clamped == '0) begin
            len_clamped = CNT_W'(1);
        end else if (len_clamped > CNT_W'(WINDOW_MAX)) begin
            len_clamped = CNT_W'(WINDOW_MAX);
        end
    end

    assign slot_sum   = {1'b0, CNT_W'(oldest_reg)} + {1'b0, fill_reg};
    assign slot_wrap  = (slot_sum >= {1'b0, len_reg}) ? slot_sum - {1'b0, len_reg} : slot_sum;
    assign oldest_inc = (CNT_W'(oldest_reg) + 1'b1 >= len_reg) ? '0 : oldest_reg + 1'b1;

    assign n_m1    = fill_reg - 1'b1;
    assign half    = fill_reg >> 1;
    assign half_lo = (half == '0) ? '0 : IDX_W'(half - 1'b1);
    assign lo_full = pos_reg[POS_W-1:Q_FRAC_BITS];
    assign pos_f   = pos_reg[Q_FRAC_BITS-1:0];
    assign lo_addr = lo_full[IDX_W-1:0];
    assign lo_next_addr = lo_addr + 1'b1;

    always_comb begin
        unique case (step_reg)
            RD_MAX:    rd_addr = IDX_W'(n_m1);
            RD_MED_HI: rd_addr = IDX_W'(half);
            RD_MED_LO: rd_addr = half_lo;
            RD_Q_LO:   rd_addr = lo_addr;
            RD_Q_HI:   rd_addr = lo_next_addr;
            default:   rd_addr = '0;
        endcase
    end

    assign q_pop          = (state_reg == S_IDLE) && q_valid;
    assign cells_cmd.remove = (state_reg == S_REMOVE);
    assign cells_cmd.insert = (state_reg == S_INSERT);
    assign op_value       = (state_reg == S_REMOVE) ? ram_rdata : sample_reg;
    assign fill           = fill_reg;

    assign ram_re    = q_pop && (fill_reg >= len_reg);
    assign ram_raddr = oldest_reg;
    assign ram_we    = (state_reg == S_INSERT);
    assign ram_waddr = slot_reg;
    assign ram_wdata = sample_reg;

    assign rem_sh = {rem_reg, quot_reg[DIV_W-1]};

    // floor average without overflow
    assign med_a     = fill_reg[0] ? med_hi_reg : med_lo_reg;
    assign med_sum   = (med_a & med_hi_reg) + ((med_a ^ med_hi_reg) >> 1);
    assign quant_sum = qa_reg + prod_reg[PROD_W-1:Q_FRAC_BITS];
    assign quant_res = (quant_reg > QUANT_ONE) ? '0 :
                       use_a_reg ? (qa_reg ^ SIGN_MASK) : (quant_sum ^ SIGN_MASK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= RD_MAX;
            len_reg       <= CNT_W'(LEN_RESET);
            quant_reg     <= QUANT_RESET;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        sample_reg <= q_data;
                        if (fill_reg >= len_reg) begin
                            slot_reg   <= oldest_reg;
                            oldest_reg <= oldest_inc;
                            state_reg  <= S_EVRD;
                        end else begin
                            slot_reg  <= IDX_W'(slot_wrap);
                            state_reg <= S_INSERT;
                        end
                    end
                end
                S_EVRD: begin
                    state_reg <= S_REMOVE;
                end
                S_REMOVE: begin
                    fill_reg  <= fill_reg - 1'b1;
                    state_reg <= S_INSERT;
                end
                S_INSERT: begin
                    fill_reg  <= fill_reg + 1'b1;
                    below_reg <= below;
                    state_reg <= S_POS;
                end
                S_POS: begin
                    pos_reg   <= POS_W'(quant_reg) * POS_W'(n_m1);
                    step_reg  <= RD_MAX;
                    state_reg <= S_RD;
                end
                S_RD: begin
                    unique case (step_reg)
                        RD_MAX: begin
                            max_reg  <= rd_data;
                            step_reg <= RD_MED_HI;
                        end
                        RD_MED_HI: begin
                            med_hi_reg <= rd_data;
                            step_reg   <= RD_MED_LO;
                        end
                        RD_MED_LO: begin
                            med_lo_reg <= rd_data;
                            step_reg   <= RD_Q_LO;
                        end
                        RD_Q_LO: begin
                            qa_reg   <= rd_data;
                            step_reg <= RD_Q_HI;
                        end
                        RD_Q_HI: begin
                            qb_reg    <= rd_data;
                            state_reg <= S_QMUL;
                        end
                        default: begin
                            step_reg <= RD_MAX;
                        end
                    endcase
                end
                S_QMUL: begin
                    prod_reg    <= PROD_W'(qb_reg - qa_reg) * PROD_W'(pos_f);
                    use_a_reg   <= (pos_f == '0) || (lo_full + 1'b1 >= LO_W'(fill_reg));
                    rem_reg     <= '0;
                    quot_reg    <= {below_reg, {Q_FRAC_BITS{1'b0}}};
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (rem_sh >= {1'b0, n_m1}) begin
                        rem_reg  <= CNT_W'(rem_sh - {1'b0, n_m1});
                        quot_reg <= {quot_reg[DIV_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh[CNT_W-1:0];
                        quot_reg <= {quot_reg[DIV_W-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCNT_W'(DIV_W - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_max_reg   <= max_reg ^ SIGN_MASK;
                        out_min_reg   <= min_data ^ SIGN_MASK;
                        out_med_reg   <= med_sum ^ SIGN_MASK;
                        out_quant_reg <= quant_res;
                        out_rank_reg  <= below_reg + 1'b1;
                        out_frac_reg  <= (fill_reg > CNT_W'(1)) ? quot_reg[FRAC_W-1:0] : FRAC_HALF;
                        out_count_reg <= fill_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg.wr_len) begin
                len_reg    <= len_clamped;
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            if (cfg.wr_quant) begin
                quant_reg <= cfg_data[FRAC_W-1:0];
            end
        end
    end

    assign len_out          = len_reg;
    assign quant_out        = quant_reg;
    assign m_tvalid         = out_valid_reg;
    assign m_window_max     = out_max_reg;
    assign m_window_min     = out_min_reg;
    assign m_median_value   = out_med_reg;
    assign m_quantile_value = out_quant_reg;
    assign m_sample_rank    = out_rank_reg;
    assign m_rank_fraction  = out_frac_reg;
    assign m_window_count   = out_count_reg;

    a_fill_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_reg)
        else $error("fill count above window length");

    a_oldest_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(oldest_reg) < len_reg)
        else $error("oldest pointer outside window");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INSERT |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("insert did not grow the window");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REMOVE |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("eviction did not shrink the window");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import swos_pkg::*;

    localparam int WMAX  = 64;
    localparam int OUT_W = 160;

    // result fields from the highest bit down, window_max in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [6:0]  count;
        logic [16:0] rfrac;
        logic [6:0]  rank;
        logic [31:0] qv;
        logic [31:0] med;
        logic [31:0] mn;
        logic [31:0] mx;
    } stats_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;   // sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;        // max, min, median, quantile, rank, rank_fraction, count
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sliding_window_order_statistics i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // window model, samples kept offset-binary so unsigned order is signed order
    logic [31:0] arrivals[WMAX];
    logic [31:0] ordered[WMAX];
    int          fill_n = 0;
    int          oldest = 0;
    int          win_len = LEN_RESET;
    logic [16:0] quant_q = QUANT_RESET;

    stats_t      expected_stats[$];
    int          errors = 0;
    int          samples_sent = 0;
    int          results_seen = 0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    logic        s_tready_n, m_tvalid_n;
    logic [OUT_W-1:0] m_tdata_n;

    always @(negedge aclk) begin
        s_tready_n <= s_tready;
        m_tvalid_n <= m_tvalid;
        m_tdata_n  <= m_tdata;
    end

    function automatic logic [31:0] flip(logic [31:0] v);
        return v ^ 32'h8000_0000;
    endfunction

    function automatic stats_t window_stats(logic [31:0] smp);
        stats_t r;
        logic [31:0] u, a, b, d;
        logic [63:0] qpos, add;
        logic [15:0] f;
        int slot, i, below, n, lo;
        u = flip(smp);
        if (fill_n >= win_len) begin
            slot = oldest;
            for (i = 0; i < fill_n; i++) begin
                if (ordered[i] == arrivals[slot]) break;
            end
            if (i < fill_n) begin
                for (int k = i; k < fill_n - 1; k++) ordered[k] = ordered[k+1];
                fill_n--;
            end
            oldest = (oldest + 1 >= win_len) ? 0 : oldest + 1;
        end else begin
            slot = oldest + fill_n;
            if (slot >= win_len) slot -= win_len;
        end
        arrivals[slot] = u;
        below = 0;
        while (below < fill_n && ordered[below] < u) below++;
        for (int k = fill_n; k > below; k--) ordered[k] = ordered[k-1];
        ordered[below] = u;
        fill_n++;
        n = fill_n;

        r = '0;
        r.mx = flip(ordered[n-1]);
        r.mn = flip(ordered[0]);
        if (n % 2 == 1) begin
            r.med = flip(ordered[n/2]);
        end else begin
            a = ordered[n/2-1];
            b = ordered[n/2];
            r.med = flip((a & b) + ((a ^ b) >> 1));
        end
        if (quant_q > QUANT_ONE) begin
            r.qv = '0;
        end else if (n == 1) begin
            r.qv = flip(ordered[0]);
        end else begin
            qpos = 64'(quant_q) * 64'(n - 1);
            lo = int'(qpos >> 16);
            f = qpos[15:0];
            a = ordered[lo];
            if (f == 0 || lo + 1 >= n) begin
                r.qv = flip(a);
            end else begin
                d = ordered[lo+1] - a;
                add = 64'(d >> 16) * 64'(f) + ((64'(d[15:0]) * 64'(f)) >> 16);
                r.qv = flip(a + add[31:0]);
            end
        end
        r.rank  = 7'(below + 1);
        r.rfrac = (n > 1) ? 17'((64'(below) * 65536) / 64'(n - 1)) : FRAC_HALF;
        r.count = 7'(n);
        return r;
    endfunction

    task automatic note_mismatch(string fname, logic [31:0] e, logic [31:0] a);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d (0x%h) got %0d (0x%h)",
                     fname, $signed(e), e, $signed(a), a);
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        if (receiver_quiet) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 16);
    end

    // result checker
    always @(posedge aclk) begin
        stats_t got, exp_s;
        if (aresetn && m_tvalid_n && m_tready) begin
            got = stats_t'(m_tdata_n);
            results_seen++;
            if (expected_stats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result transaction with nothing expected");
            end else begin
                exp_s = expected_stats.pop_front();
                if (got.mx !== exp_s.mx) note_mismatch("window_max", exp_s.mx, got.mx);
                if (got.mn !== exp_s.mn) note_mismatch("window_min", exp_s.mn, got.mn);
                if (got.med !== exp_s.med) note_mismatch("median_value", exp_s.med, got.med);
                if (got.qv !== exp_s.qv) note_mismatch("quantile_value", exp_s.qv, got.qv);
                if (got.rank !== exp_s.rank) note_mismatch("sample_rank", 32'(exp_s.rank), 32'(got.rank));
                if (got.rfrac !== exp_s.rfrac)
                    note_mismatch("rank_fraction", 32'(exp_s.rfrac), 32'(got.rfrac));
                if (got.count !== exp_s.count)
                    note_mismatch("window_count", 32'(exp_s.count), 32'(got.count));
            end
        end
    end

    task automatic send_sample(logic [31:0] v);
        while (!sender_quiet && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready_n);
        expected_stats.insert(expected_stats.size(), window_stats(v));
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WINDOW_LENGTH) begin
            win_len = int'(val[6:0]);
            if (win_len < 1) win_len = 1;
            if (win_len > WMAX) win_len = WMAX;
            fill_n = 0;
            oldest = 0;
        end else begin
            quant_q = val[16:0];
        end
    endtask

    task automatic configure(int len, int q);
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 32'(len));
        write_reg(REG_QUANTILE, 32'(q));
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(4))
            0: return 32'($signed($urandom_range(8)) - 4);   // many ties
            1: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] vals[12] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h5, 32'h5,
                                  32'h5, 32'hffff_fffb, 32'h1, 32'h5};
        configure(4, 32768);
        foreach (vals[i]) send_sample(vals[i]);
        // single sample window
        configure(1, 16384);
        send_sample(32'h1234_5678);
        send_sample(32'h8000_0000);
    endtask

    task automatic test_register_edges();
        int lens[5]   = '{0, 127, 2, 64, 3};
        int quants[5] = '{0, 65536, 65537, 131071, 1};
        foreach (lens[i]) begin
            configure(lens[i], quants[i]);
            repeat (3) send_sample(pick_sample());
        end
    endtask

    task automatic test_random_windows();
        int lens[8] = '{1, 2, 5, 20, 33, 64, 64, 7};
        for (int ph = 0; ph < 8; ph++) begin
            configure(lens[ph], ph == 7 ? 65536 : $urandom_range(65536));
            sender_quiet   = (ph == 5);
            receiver_quiet = (ph == 5);
            for (int k = 0; k < 215; k++) begin
                if (k == 100 && ph == 3) wait_idle();
                send_sample(pick_sample());
            end
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset defaults first
        repeat (25) send_sample(pick_sample());
        test_extremes();
        test_register_edges();
        test_random_windows();
        wait_idle();
        $display("%0d samples sent, %0d results checked over window lengths 1..64",
                 samples_sent, results_seen);
        $display("quantiles 0 to 1 plus out-of-range, ties and signed extremes included");
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("** sliding_window_order_statistics: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_stats.size());
            $display("** sliding_window_order_statistics: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("** sliding_window_order_statistics: FAILED **");
        $finish;
    end

endmodule
